### hdl/chs_pkg.sv
// Shared constants, types and helper functions for the chained hash set.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package chs_pkg;

    localparam int MAX_BUCKETS  = 4096;
    localparam int POOL_ENTRIES = 4096;
    localparam int PRIME_STEPS  = 10;
    localparam int NUM_LISTED   = 10;

    localparam int KEY_W      = 31;
    localparam int BC_W       = 12;
    localparam int ST_W       = 2;
    localparam int CMD_W      = 2;
    localparam int REQ_W      = 13;
    localparam int LIM_W      = 11;
    localparam int Q_FRAC     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int STEP_W     = 4;
    localparam int OP_W       = 5;

    localparam int BKT_AW = $clog2(MAX_BUCKETS);
    localparam int ENT_AW = $clog2(POOL_ENTRIES);
    localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [BC_W-1:0]  t_bc;
    typedef logic [OP_W-1:0]  t_op;

    // pointer value that marks an empty chain or an exhausted list
    localparam t_ptr EMPTY = t_ptr'(POOL_ENTRIES);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_REQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [ST_W-1:0] ST_POOL_FULL = 2'd2;

    localparam logic [REQ_W-1:0] REQ_RESET   = 13'd3;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd192;

    // datapath commands
    localparam t_op OP_NONE   = 5'd0;
    localparam t_op OP_CLR    = 5'd1;
    localparam t_op OP_LATCH  = 5'd2;
    localparam t_op OP_GROW   = 5'd3;
    localparam t_op OP_RSTART = 5'd4;
    localparam t_op OP_STAT1  = 5'd5;
    localparam t_op OP_RCLR   = 5'd6;
    localparam t_op OP_RHREAD = 5'd7;
    localparam t_op OP_RHD    = 5'd8;
    localparam t_op OP_RENT   = 5'd9;
    localparam t_op OP_RKEY   = 5'd10;
    localparam t_op OP_RDIV   = 5'd11;
    localparam t_op OP_RLINK  = 5'd12;
    localparam t_op OP_RSWAP  = 5'd13;
    localparam t_op OP_HASH   = 5'd14;
    localparam t_op OP_HDIV   = 5'd15;
    localparam t_op OP_HD     = 5'd16;
    localparam t_op OP_EW     = 5'd17;
    localparam t_op OP_POPREQ = 5'd18;
    localparam t_op OP_POP    = 5'd19;
    localparam t_op OP_FRESH  = 5'd20;
    localparam t_op OP_STAT2  = 5'd21;
    localparam t_op OP_INS    = 5'd22;
    localparam t_op OP_REM1   = 5'd23;
    localparam t_op OP_REM2   = 5'd24;
    localparam t_op OP_OUT    = 5'd25;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic cfg_init;
        logic is_insert;
        logic is_remove;
        logic grow;
        logic can_grow;
        logic ok;
        logic found;
        logic div_busy;
        logic head_empty;
        logic key_match;
        logic link_empty;
        logic nxt_empty;
        logic idx_last_cur;
        logic idx_last_new;
        logic free_avail;
        logic fresh_avail;
        logic prev_empty;
        logic out_free;
    } t_sts;

    function automatic t_bc prime_at(input logic [STEP_W-1:0] i);
        t_bc p;
        case (i)
            4'd0:    p = 12'd3;
            4'd1:    p = 12'd7;
            4'd2:    p = 12'd23;
            4'd3:    p = 12'd47;
            4'd4:    p = 12'd103;
            4'd5:    p = 12'd211;
            4'd6:    p = 12'd431;
            4'd7:    p = 12'd859;
            4'd8:    p = 12'd1721;
            4'd9:    p = 12'd3461;
            default: p = 12'd3461;
        endcase
        return p;
    endfunction

    function automatic int last_step();
        int t;
        t = 0;
        for (int i = 0; i < NUM_LISTED && i < PRIME_STEPS; i++)
            if (int'(prime_at(STEP_W'(i))) <= MAX_BUCKETS)
                t = i;
        return t;
    endfunction

    localparam int TOP_STEP = last_step();

    // first usable prime at or above the request, capped at the largest
    function automatic logic [STEP_W-1:0] step_for(input logic [REQ_W-1:0] req);
        logic [STEP_W-1:0] s;
        s = STEP_W'(TOP_STEP);
        for (int i = NUM_LISTED - 1; i >= 0; i--)
            if (i <= TOP_STEP && req <= REQ_W'(prime_at(STEP_W'(i))))
                s = STEP_W'(i);
        return s;
    endfunction

endpackage
`default_nettype wire

### hdl/chs_divider.sv
// Bit-serial remainder unit: key modulo a bucket count, one quotient bit per cycle.
// Depends on chs_pkg.
`default_nettype none
module chs_divider (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [chs_pkg::KEY_W-1:0] i_dividend,
    input  wire chs_pkg::t_bc          i_divisor,
    output logic                       o_busy,
    output chs_pkg::t_bc               o_rem
);
    import chs_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_dvd;
    t_bc              r_div;
    logic [BC_W:0]    r_rem;
    logic [BC_W:0]    n_rem;
    logic [BC_W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem[BC_W-1:0], r_dvd[KEY_W-1]};
        if (w_trial >= {1'b0, r_div})
            n_rem = w_trial - {1'b0, r_div};
        else
            n_rem = w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(KEY_W - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[BC_W-1:0];

endmodule
`default_nettype wire

### hdl/chs_ctrl.sv
// Sequencing state machine for the hash set: lookup, insert, remove, rehash, clear.
// Depends on chs_pkg; drives chs_datapath through t_ctl and reads t_sts.
`default_nettype none
module chs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire chs_pkg::t_sts i_sts,
    output chs_pkg::t_ctl      o_ctl
);
    import chs_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_START  = 5'd2;
    localparam logic [4:0] S_CHK    = 5'd3;
    localparam logic [4:0] S_RCLR   = 5'd4;
    localparam logic [4:0] S_RHEAD  = 5'd5;
    localparam logic [4:0] S_RHD    = 5'd6;
    localparam logic [4:0] S_RENT   = 5'd7;
    localparam logic [4:0] S_RKEY   = 5'd8;
    localparam logic [4:0] S_RDIV   = 5'd9;
    localparam logic [4:0] S_RLINK  = 5'd10;
    localparam logic [4:0] S_RSWAP  = 5'd11;
    localparam logic [4:0] S_HASH   = 5'd12;
    localparam logic [4:0] S_HDIV   = 5'd13;
    localparam logic [4:0] S_HD     = 5'd14;
    localparam logic [4:0] S_EW     = 5'd15;
    localparam logic [4:0] S_ACT    = 5'd16;
    localparam logic [4:0] S_POPREQ = 5'd17;
    localparam logic [4:0] S_POP    = 5'd18;
    localparam logic [4:0] S_FRESH  = 5'd19;
    localparam logic [4:0] S_STAT2  = 5'd20;
    localparam logic [4:0] S_INS    = 5'd21;
    localparam logic [4:0] S_REM1   = 5'd22;
    localparam logic [4:0] S_REM2   = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.op = OP_CLR;
                if (i_sts.idx_last_cur)
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                // a resize write wins; no input transfer in that cycle
                o_in_ready = !i_sts.cfg_init;
                if (i_sts.cfg_init) begin
                    n_state = S_CLEAR;
                end else if (i_in_valid) begin
                    o_ctl.op = OP_LATCH;
                    n_state  = S_START;
                end
            end
            S_START: begin
                o_ctl.op = OP_GROW;
                n_state  = i_sts.is_insert ? S_CHK : S_HASH;
            end
            S_CHK: begin
                if (i_sts.grow && i_sts.can_grow) begin
                    o_ctl.op = OP_RSTART;
                    n_state  = S_RCLR;
                end else begin
                    if (i_sts.grow)
                        o_ctl.op = OP_STAT1;
                    n_state = S_HASH;
                end
            end
            S_RCLR: begin
                o_ctl.op = OP_RCLR;
                if (i_sts.idx_last_new)
                    n_state = S_RHEAD;
            end
            S_RHEAD: begin
                o_ctl.op = OP_RHREAD;
                n_state  = S_RHD;
            end
            S_RHD: begin
                o_ctl.op = OP_RHD;
                if (!i_sts.head_empty)
                    n_state = S_RENT;
                else
                    n_state = i_sts.idx_last_cur ? S_RSWAP : S_RHEAD;
            end
            S_RENT: begin
                o_ctl.op = OP_RENT;
                n_state  = S_RKEY;
            end
            S_RKEY: begin
                o_ctl.op = OP_RKEY;
                n_state  = S_RDIV;
            end
            S_RDIV: begin
                o_ctl.op = OP_RDIV;
                if (!i_sts.div_busy)
                    n_state = S_RLINK;
            end
            S_RLINK: begin
                o_ctl.op = OP_RLINK;
                if (!i_sts.nxt_empty)
                    n_state = S_RENT;
                else
                    n_state = i_sts.idx_last_cur ? S_RSWAP : S_RHEAD;
            end
            S_RSWAP: begin
                o_ctl.op = OP_RSWAP;
                n_state  = S_HASH;
            end
            S_HASH: begin
                o_ctl.op = OP_HASH;
                n_state  = S_HDIV;
            end
            S_HDIV: begin
                o_ctl.op = OP_HDIV;
                if (!i_sts.div_busy)
                    n_state = S_HD;
            end
            S_HD: begin
                o_ctl.op = OP_HD;
                n_state  = i_sts.head_empty ? S_ACT : S_EW;
            end
            S_EW: begin
                o_ctl.op = OP_EW;
                if (i_sts.key_match || i_sts.link_empty)
                    n_state = S_ACT;
            end
            S_ACT: begin
                n_state = S_OUT;
                if (i_sts.is_insert) begin
                    if (i_sts.ok && !i_sts.found) begin
                        if (i_sts.free_avail)
                            n_state = S_POPREQ;
                        else if (i_sts.fresh_avail)
                            n_state = S_FRESH;
                        else
                            n_state = S_STAT2;
                    end
                end else if (i_sts.is_remove && i_sts.found) begin
                    n_state = S_REM1;
                end
            end
            S_POPREQ: begin
                o_ctl.op = OP_POPREQ;
                n_state  = S_POP;
            end
            S_POP: begin
                o_ctl.op = OP_POP;
                n_state  = S_INS;
            end
            S_FRESH: begin
                o_ctl.op = OP_FRESH;
                n_state  = S_INS;
            end
            S_STAT2: begin
                o_ctl.op = OP_STAT2;
                n_state  = S_OUT;
            end
            S_INS: begin
                o_ctl.op = OP_INS;
                n_state  = S_OUT;
            end
            S_REM1: begin
                o_ctl.op = OP_REM1;
                n_state  = i_sts.prev_empty ? S_OUT : S_REM2;
            end
            S_REM2: begin
                o_ctl.op = OP_REM2;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hdl/chs_datapath.sv
// Tables, pointers and counters of the hash set; executes one command per cycle.
// Depends on chs_pkg and chs_divider; commanded by chs_ctrl.
`default_nettype none
module chs_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire chs_pkg::t_ctl                 i_ctl,
    output chs_pkg::t_sts                      o_sts,
    input  wire logic [chs_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [chs_pkg::KEY_W-1:0]     i_key,
    input  wire logic                          i_cfg_valid,
    input  wire logic [chs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [chs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [chs_pkg::ST_W-1:0]           o_status,
    output chs_pkg::t_bc                       o_bucket_count
);
    import chs_pkg::*;

    // storage
    logic [KEY_W-1:0] r_keys  [POOL_ENTRIES];
    t_ptr             r_links [POOL_ENTRIES];
    t_ptr             r_heads0[MAX_BUCKETS];
    t_ptr             r_heads1[MAX_BUCKETS];

    // control state
    t_bc               r_cur;
    logic [STEP_W-1:0] r_step;
    logic [LIM_W-1:0]  r_limit;
    t_bc               r_occ;
    t_ptr              r_free_head;
    t_ptr              r_fresh;
    logic              r_bank;
    t_bc               r_idx;
    logic              r_out_valid;

    // per-item work registers
    logic [KEY_W-1:0]  r_key;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_found;
    logic [ST_W-1:0]   r_status;
    t_bc               r_b;
    t_ptr              r_e;
    t_ptr              r_prev;
    t_ptr              r_nxt;
    t_ptr              r_head;
    t_ptr              r_n;
    t_bc               r_new;
    t_bc               r_occ_new;
    logic              r_grow;
    logic              r_out_found;
    logic [ST_W-1:0]   r_out_status;
    t_bc               r_out_bc;

    // memory ports
    logic              key_we, key_re, link_we, link_re;
    logic [ENT_AW-1:0] key_wa, key_ra, link_wa, link_ra;
    logic [KEY_W-1:0]  key_wd, key_q;
    t_ptr              link_wd, link_q;
    logic              act_we, act_re, spr_we, spr_re;
    logic [BKT_AW-1:0] act_wa, act_ra, spr_wa, spr_ra;
    t_ptr              act_wd, spr_wd, act_q, spr_q;
    t_ptr              h0_q, h1_q;

    logic              div_start, div_busy;
    logic [KEY_W-1:0]  div_dvd;
    t_bc               div_dvs, div_rem;

    logic [BC_W+LIM_W-1:0] w_lhs, w_rhs;
    logic [STEP_W-1:0]     w_init_step;
    logic                  w_cfg_req;

    assign w_cfg_req   = i_cfg_valid && i_cfg_index == CFG_REQ;
    assign w_init_step = step_for(i_cfg_data);
    assign w_lhs       = (BC_W+LIM_W)'({r_occ, {Q_FRAC{1'b0}}});
    assign w_rhs       = (BC_W+LIM_W)'(r_cur) * (BC_W+LIM_W)'(r_limit);

    assign div_start = i_ctl.op == OP_HASH || i_ctl.op == OP_RKEY;
    assign div_dvd   = (i_ctl.op == OP_RKEY) ? key_q : r_key;
    assign div_dvs   = (i_ctl.op == OP_RKEY) ? r_new : r_cur;

    chs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    // memory port steering
    always_comb begin
        key_we = 1'b0; key_re = 1'b0; link_we = 1'b0; link_re = 1'b0;
        act_we = 1'b0; act_re = 1'b0; spr_we = 1'b0; spr_re = 1'b0;
        key_wa = '0; key_ra = '0; link_wa = '0; link_ra = '0;
        key_wd = r_key; link_wd = EMPTY;
        act_wa = '0; act_ra = '0; spr_wa = '0; spr_ra = '0;
        act_wd = EMPTY; spr_wd = EMPTY;
        case (i_ctl.op)
            OP_CLR: begin
                act_we = 1'b1;
                act_wa = BKT_AW'(r_idx);
            end
            OP_RCLR: begin
                spr_we = 1'b1;
                spr_wa = BKT_AW'(r_idx);
            end
            OP_RHREAD: begin
                act_re = 1'b1;
                act_ra = BKT_AW'(r_idx);
            end
            OP_RENT: begin
                key_re  = 1'b1;
                link_re = 1'b1;
                key_ra  = r_e[ENT_AW-1:0];
                link_ra = r_e[ENT_AW-1:0];
            end
            OP_RDIV: begin
                spr_re = !div_busy;
                spr_ra = BKT_AW'(div_rem);
            end
            OP_RLINK: begin
                link_we = 1'b1;
                link_wa = r_e[ENT_AW-1:0];
                link_wd = spr_q;
                spr_we  = 1'b1;
                spr_wa  = BKT_AW'(r_b);
                spr_wd  = r_e;
            end
            OP_HDIV: begin
                act_re = !div_busy;
                act_ra = BKT_AW'(div_rem);
            end
            OP_HD: begin
                key_re  = act_q != EMPTY;
                link_re = act_q != EMPTY;
                key_ra  = act_q[ENT_AW-1:0];
                link_ra = act_q[ENT_AW-1:0];
            end
            OP_EW: begin
                key_re  = key_q != r_key && link_q != EMPTY;
                link_re = key_q != r_key && link_q != EMPTY;
                key_ra  = link_q[ENT_AW-1:0];
                link_ra = link_q[ENT_AW-1:0];
            end
            OP_POPREQ: begin
                link_re = 1'b1;
                link_ra = r_free_head[ENT_AW-1:0];
            end
            OP_INS: begin
                key_we  = 1'b1;
                key_wa  = r_n[ENT_AW-1:0];
                link_we = 1'b1;
                link_wa = r_n[ENT_AW-1:0];
                link_wd = r_head;
                act_we  = 1'b1;
                act_wa  = BKT_AW'(r_b);
                act_wd  = r_n;
            end
            OP_REM1: begin
                link_we = 1'b1;
                link_wa = r_e[ENT_AW-1:0];
                link_wd = r_free_head;
                act_we  = r_prev == EMPTY;
                act_wa  = BKT_AW'(r_b);
                act_wd  = r_nxt;
            end
            OP_REM2: begin
                link_we = 1'b1;
                link_wa = r_prev[ENT_AW-1:0];
                link_wd = r_nxt;
            end
            default: begin
                key_we = 1'b0;
            end
        endcase
    end

    // memories, registered read
    always_ff @(posedge i_clk) begin
        if (key_we)
            r_keys[key_wa] <= key_wd;
        if (key_re)
            key_q <= r_keys[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we)
            r_links[link_wa] <= link_wd;
        if (link_re)
            link_q <= r_links[link_ra];
    end

    // bank 0/1 alternate as live table and rehash target
    always_ff @(posedge i_clk) begin
        if (act_we && !r_bank)
            r_heads0[act_wa] <= act_wd;
        else if (spr_we && r_bank)
            r_heads0[spr_wa] <= spr_wd;
        if (act_re && !r_bank)
            h0_q <= r_heads0[act_ra];
        else if (spr_re && r_bank)
            h0_q <= r_heads0[spr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (act_we && r_bank)
            r_heads1[act_wa] <= act_wd;
        else if (spr_we && !r_bank)
            r_heads1[spr_wa] <= spr_wd;
        if (act_re && r_bank)
            h1_q <= r_heads1[act_ra];
        else if (spr_re && !r_bank)
            h1_q <= r_heads1[spr_ra];
    end

    assign act_q = r_bank ? h1_q : h0_q;
    assign spr_q = r_bank ? h0_q : h1_q;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= step_for(REQ_RESET);
            r_cur       <= prime_at(step_for(REQ_RESET));
            r_limit     <= LIMIT_RESET;
            r_occ       <= '0;
            r_free_head <= EMPTY;
            r_fresh     <= '0;
            r_bank      <= 1'b0;
            r_idx       <= '0;
        end else if (w_cfg_req) begin
            r_step      <= w_init_step;
            r_cur       <= prime_at(w_init_step);
            r_occ       <= '0;
            r_free_head <= EMPTY;
            r_fresh     <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_LIMIT)
                r_limit <= i_cfg_data[LIM_W-1:0];
            case (i_ctl.op)
                OP_CLR:    r_idx <= r_idx + 1'b1;
                OP_RSTART: r_idx <= '0;
                OP_RCLR:   r_idx <= o_sts.idx_last_new ? '0 : r_idx + 1'b1;
                OP_RHD: begin
                    if (act_q == EMPTY)
                        r_idx <= r_idx + 1'b1;
                end
                OP_RLINK: begin
                    if (r_nxt == EMPTY)
                        r_idx <= r_idx + 1'b1;
                end
                OP_RSWAP: begin
                    r_bank <= ~r_bank;
                    r_cur  <= r_new;
                    r_step <= r_step + 1'b1;
                    r_occ  <= r_occ_new;
                    r_idx  <= '0;
                end
                OP_POP:   r_free_head <= link_q;
                OP_FRESH: r_fresh <= r_fresh + 1'b1;
                OP_INS: begin
                    if (r_head == EMPTY)
                        r_occ <= r_occ + 1'b1;
                end
                OP_REM1: begin
                    r_free_head <= r_e;
                    if (r_prev == EMPTY && r_nxt == EMPTY && r_occ != '0)
                        r_occ <= r_occ - 1'b1;
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LATCH: begin
                r_key    <= i_key;
                r_cmd    <= i_cmd;
                r_found  <= 1'b0;
                r_status <= ST_OK;
            end
            OP_GROW:   r_grow <= w_lhs > w_rhs;
            OP_RSTART: begin
                r_new     <= prime_at(r_step + 1'b1);
                r_occ_new <= '0;
            end
            OP_STAT1:  r_status <= ST_TOO_LARGE;
            OP_RHD:    r_e <= act_q;
            OP_RKEY:   r_nxt <= link_q;
            OP_RDIV: begin
                if (!div_busy)
                    r_b <= div_rem;
            end
            OP_RLINK: begin
                if (spr_q == EMPTY)
                    r_occ_new <= r_occ_new + 1'b1;
                r_e <= r_nxt;
            end
            OP_HDIV: begin
                if (!div_busy)
                    r_b <= div_rem;
            end
            OP_HD: begin
                r_e    <= act_q;
                r_head <= act_q;
                r_prev <= EMPTY;
            end
            OP_EW: begin
                if (key_q == r_key) begin
                    r_found <= 1'b1;
                    r_nxt   <= link_q;
                end else begin
                    r_prev <= r_e;
                    r_e    <= link_q;
                end
            end
            OP_POP:   r_n <= r_free_head;
            OP_FRESH: r_n <= r_fresh;
            OP_STAT2: r_status <= ST_POOL_FULL;
            OP_OUT: begin
                r_out_found  <= r_found;
                r_out_status <= r_status;
                r_out_bc     <= r_cur;
            end
            default: begin
                r_grow <= r_grow;
            end
        endcase
    end

    // result register, parts the result side from the work in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_status       = r_out_status;
    assign o_bucket_count = r_out_bc;

    always_comb begin
        o_sts.cfg_init     = w_cfg_req;
        o_sts.is_insert    = r_cmd == CMD_INSERT;
        o_sts.is_remove    = r_cmd == CMD_REMOVE;
        o_sts.grow         = r_grow;
        o_sts.can_grow     = r_step < STEP_W'(TOP_STEP);
        o_sts.ok           = r_status == ST_OK;
        o_sts.found        = r_found;
        o_sts.div_busy     = div_busy;
        o_sts.head_empty   = act_q == EMPTY;
        o_sts.key_match    = key_q == r_key;
        o_sts.link_empty   = link_q == EMPTY;
        o_sts.nxt_empty    = r_nxt == EMPTY;
        o_sts.idx_last_cur = r_idx == r_cur - 1'b1;
        o_sts.idx_last_new = r_idx == r_new - 1'b1;
        o_sts.free_avail   = r_free_head != EMPTY;
        o_sts.fresh_avail  = r_fresh != EMPTY;
        o_sts.prev_empty   = r_prev == EMPTY;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    a_cur_is_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur == prime_at(r_step))
        else $error("bucket count out of step with prime index");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_cur)
        else $error("occupied buckets exceed bucket count");

    a_swap_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == OP_RSWAP |=> r_cur == $past(r_new))
        else $error("rehash did not adopt new size");

    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == OP_INS |-> (r_n != EMPTY && r_n != r_free_head))
        else $error("insert uses an invalid or still-free entry");

endmodule
`default_nettype wire

### hdl/chained_hash_set.sv
// Chained hash set: a set of 31-bit keys in a separate-chaining table of prime size.
//
// Input channel (i_in_valid/o_in_ready, i_cmd, i_key): insert, remove or find.
// Output channel (o_out_valid/i_out_ready): one result per command, in order:
// o_found, o_status, o_bucket_count.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets the
// requested bucket count and empties the set; index 1 sets the load limit.
// One command at a time. A find runs its key through the bit-serial modulo
// unit, reads the bucket head and compares chain entries one by one. An insert
// adds the load check and the update, taking an entry from the free list or the
// unused pool; a remove unlinks its entry from the bucket head or its predecessor.
// An insert that grows the table first rehashes: it clears the target table,
// walks each old bucket and relinks every stored key, one modulo each.
// After reset, and after a write of register 0 while idle, the live bucket
// table is cleared one entry per cycle up to the bucket count (3 after reset);
// no command is taken meanwhile.
// The result register lets a new command be taken while a result waits; a
// finished command holds in its last step until the output is free.
// Depends on chs_pkg, chs_ctrl, chs_datapath.
`default_nettype none
module chained_hash_set (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [chs_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [chs_pkg::KEY_W-1:0]     i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_found,
    output logic [chs_pkg::ST_W-1:0]           o_status,
    output logic [chs_pkg::BC_W-1:0]           o_bucket_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [chs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [chs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import chs_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    chs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_bucket_count (o_bucket_count)
    );

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for chained_hash_set: directed, growth, stall and random tests.
// Keeps its own set-based prediction of each result and checks every output transfer.
// Depends on chs_pkg and the chained_hash_set RTL.
`timescale 1ns / 100ps
module tb_top;
    import chs_pkg::*;

    typedef struct {
        logic            found;
        logic [ST_W-1:0] status;
        logic [BC_W-1:0] buckets;
    } t_result;

    localparam int TOP_IDX = 9;
    localparam int RAND_ITEMS = 500;
    localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ALT  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_cmd;
    logic [KEY_W-1:0]      i_key;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_found;
    logic [ST_W-1:0]       o_status;
    logic [BC_W-1:0]       o_bucket_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    chained_hash_set dut (.*);

    // predicted table: the key set plus per-bucket key counts
    bit      key_set [logic [KEY_W-1:0]];
    int      bucket_fill [MAX_BUCKETS];
    int      busy_buckets;
    int      size_step;
    int      bucket_total;
    int      load_q8;
    int      primes [10] = '{3, 7, 23, 47, 103, 211, 431, 859, 1721, 3461};
    t_result pending_results [$];
    logic [KEY_W-1:0] used_keys [$];
    int      errors;
    int      rx_hold;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void recount_buckets();
        busy_buckets = 0;
        for (int i = 0; i < MAX_BUCKETS; i++) bucket_fill[i] = 0;
        foreach (key_set[k]) begin
            if (bucket_fill[k % bucket_total] == 0) busy_buckets++;
            bucket_fill[k % bucket_total]++;
        end
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, int val);
        if (idx == CFG_REQ) begin
            size_step = TOP_IDX;
            for (int i = TOP_IDX; i >= 0; i--)
                if (val <= primes[i]) size_step = i;
            bucket_total = primes[size_step];
            key_set.delete();
            recount_buckets();
        end else if (idx == CFG_LIMIT) begin
            load_q8 = val;
        end
    endfunction

    function automatic t_result predict_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        t_result r;
        int b;
        r.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (longint'(busy_buckets) * 256 > longint'(bucket_total) * load_q8) begin
                if (size_step >= TOP_IDX) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    size_step++;
                    bucket_total = primes[size_step];
                    recount_buckets();
                end
            end
            r.found = key_set.exists(key);
            if (r.status == ST_OK && !r.found) begin
                if (key_set.num() >= POOL_ENTRIES) begin
                    r.status = ST_POOL_FULL;
                end else begin
                    b = key % bucket_total;
                    key_set[key] = 1'b1;
                    if (bucket_fill[b] == 0) busy_buckets++;
                    bucket_fill[b]++;
                end
            end
        end else if (cmd == CMD_REMOVE) begin
            r.found = key_set.exists(key);
            if (r.found) begin
                b = key % bucket_total;
                key_set.delete(key);
                bucket_fill[b]--;
                if (bucket_fill[b] == 0) busy_buckets--;
            end
        end else begin
            r.found = key_set.exists(key);
        end
        r.buckets = BC_W'(bucket_total);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0d status=%0d buckets=%0d",
                         $time, o_found, o_status, o_bucket_count);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_found !== e.found) begin
                    $display("%0t: found expected %0d actual %0d", $time, e.found, o_found);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_bucket_count !== e.buckets) begin
                    $display("%0t: bucket_count expected %0d actual %0d",
                             $time, e.buckets, o_bucket_count);
                    errors++;
                end
            end
        end
    end

    // receiver: random ready, with random hold-offs and longer ones on request
    always @(negedge i_clk) begin
        int r;
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) i_out_ready <= 1'b1;
            else if (r < 97) i_out_ready <= ($urandom_range(0, 1) == 1);
            else begin
                i_out_ready <= 1'b0;
                rx_hold = $urandom_range(5, 40);
            end
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, bit no_gap = 0);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (no_gap || r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_key = key;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_command(cmd, key));
        if (used_keys.size() < 256) used_keys.push_back(key);
        else used_keys[$urandom_range(0, 255)] = key;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int val);
        drain();
        i_cfg_index = idx;
        i_cfg_data = CFG_DATA_W'(val);
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return KEY_W'($urandom_range(0, 63));
        if (r < 70 && used_keys.size() > 0) return used_keys[$urandom_range(0, used_keys.size()-1)];
        if (r < 95) return KEY_W'($urandom());
        return KEY_W'(32'h7FFF_FFFF - $urandom_range(0, 3));
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return CMD_INSERT;
        if (r < 75) return CMD_REMOVE;
        if (r < 95) return CMD_FIND;
        return CMD_ALT;
    endfunction

    // reset values; collisions in the 3-bucket table, chain head and middle unlinks
    task automatic test_directed();
        send_command(CMD_FIND, '0);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, 31'd3);
        send_command(CMD_INSERT, 31'd6);
        send_command(CMD_INSERT, 31'h7FFF_FFFF);
        send_command(CMD_FIND, 31'd3);
        send_command(CMD_ALT, 31'd6);
        send_command(CMD_REMOVE, 31'd3);
        send_command(CMD_REMOVE, 31'd3);
        send_command(CMD_REMOVE, 31'd6);
        send_command(CMD_FIND, 31'h7FFF_FFFF);
        send_command(CMD_INSERT, 31'h5555_5555);
        send_command(CMD_INSERT, 31'h2AAA_AAAA);
        send_command(CMD_INSERT, 31'd1);
        send_command(CMD_INSERT, 31'd2);
        send_command(CMD_INSERT, 31'd3);
        send_command(CMD_REMOVE, 31'h7FFF_FFFF);
        send_command(CMD_ALT, 31'd1);
        send_command(CMD_INSERT, 31'd4);
    endtask

    // largest table, zero limit: the second occupied bucket asks to grow past the top
    task automatic test_too_large();
        write_register(CFG_REQ, 8191);
        write_register(CFG_LIMIT, 0);
        send_command(CMD_INSERT, 31'd10);
        send_command(CMD_INSERT, 31'd11);
        send_command(CMD_INSERT, 31'd10);
        send_command(CMD_FIND, 31'd11);
        drain();
        write_register(CFG_REQ, 0);
        for (int i = 0; i < 12; i++) send_command(CMD_INSERT, KEY_W'(i * 5 + 1));
    endtask

    task automatic test_backpressure();
        drain();
        rx_hold = 300;
        for (int i = 0; i < 20; i++) send_command(pick_cmd(), pick_key(), 1);
        drain();
    endtask

    task automatic test_random();
        int settings [4][2] = '{'{3, 192}, '{1, 1024}, '{50, 1}, '{0, 256}};
        for (int p = 0; p < 4; p++) begin
            write_register(CFG_REQ, (p == 2) ? $urandom_range(0, 120) : settings[p][0]);
            write_register(CFG_LIMIT, (p == 3) ? $urandom_range(1, 1024) : settings[p][1]);
            for (int i = 0; i < RAND_ITEMS / 4; i++) begin
                send_command(pick_cmd(), pick_key());
                if (i == 60 && p == 1) drain();
            end
        end
        drain();
    endtask

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        errors = 0;
        rx_hold = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_cmd = CMD_INSERT;
        i_key = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_REQ;
        i_cfg_data = '0;
        apply_config(CFG_LIMIT, 192);
        apply_config(CFG_REQ, 3);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_too_large();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
